### design/poly_pkg.sv
// Shared widths, key clamp and configuration register codes for the Poly1305 MAC.
package poly_pkg;

    localparam int ACC_W   = 131;  // loosely reduced accumulator, value < 2^131
    localparam int SUM_W   = 132;  // accumulator plus message word
    localparam int MSG_W   = 129;  // padded message word, bit 128 included
    localparam int TAG_W   = 128;
    localparam int R_BITS  = 124;  // clamped r has no bit at or above 124
    localparam int CNT_W   = 7;    // holds R_BITS - 1
    localparam int HALF_W  = 64;
    localparam int CFG_A_W = 2;

    localparam logic [TAG_W-1:0] R_CLAMP = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_R_LOW  = 2'd0,
        CFG_R_HIGH = 2'd1,
        CFG_S_LOW  = 2'd2,
        CFG_S_HIGH = 2'd3
    } t_cfg_reg;

endpackage

### design/poly_mmul.sv
// Bit-serial modular multiplier: product of a and r mod 2^130-5, one bit of r per cycle.
module poly_mmul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [poly_pkg::SUM_W-1:0]  i_a,
    input  logic [poly_pkg::R_BITS-1:0] i_r,
    output logic                        o_done,
    output logic [poly_pkg::ACC_W-1:0]  o_prod
);

    logic                        r_busy;
    logic                        r_done;
    logic [poly_pkg::CNT_W-1:0]  r_cnt;
    logic [poly_pkg::R_BITS-1:0] r_r;
    logic [poly_pkg::SUM_W-1:0]  r_a;
    logic [poly_pkg::ACC_W-1:0]  r_acc;

    logic [poly_pkg::SUM_W:0]    n_t;
    logic [5:0]                  n_fold;
    logic [poly_pkg::ACC_W-1:0]  n_acc;

    // Horner step, MSB of r first: acc = 2*acc + bit*a, then fold bits 130+ by 5
    always_comb begin
        n_t    = {1'b0, r_acc, 1'b0}
               + {1'b0, (r_r[poly_pkg::R_BITS-1] ? r_a : {poly_pkg::SUM_W{1'b0}})};
        n_fold = {3'b000, n_t[poly_pkg::SUM_W:130]} * 6'd5;
        n_acc  = {1'b0, n_t[129:0]} + {{(poly_pkg::ACC_W-6){1'b0}}, n_fold};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= poly_pkg::CNT_W'(poly_pkg::R_BITS - 1);
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r <= i_r;
            r_a <= i_a;
        end else if (r_busy) begin
            r_r <= {r_r[poly_pkg::R_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

`ifndef SYNTH
    // after a fold the value is below 2^130 + 35
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc[130] |-> (r_acc[129:6] == '0))
        else $error("accumulator left its reduced range");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == '0) |=> (r_done && !r_busy))
        else $error("multiplier did not finish on its last bit");
`endif

endmodule

### design/poly_fin.sv
// Final reduction mod 2^130-5 and pad addition, three registered stages.
module poly_fin (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [poly_pkg::ACC_W-1:0] i_h,
    input  logic [poly_pkg::TAG_W-1:0] i_s,
    output logic                       o_done,
    output logic [poly_pkg::TAG_W-1:0] o_tag
);

    logic                       r_v1, r_v2, r_v3;
    logic [poly_pkg::ACC_W-1:0] r_f;
    logic [poly_pkg::TAG_W-1:0] r_sel;
    logic [poly_pkg::TAG_W-1:0] r_tag;

    logic [poly_pkg::ACC_W-1:0] n_f;
    logic [poly_pkg::ACC_W-1:0] n_g;

    always_comb begin
        // fold bit 130 back in: f < 2^130 + 5
        n_f = {1'b0, i_h[129:0]} + poly_pkg::ACC_W'(i_h[130] ? 3'd5 : 3'd0);
        // g = f - p when bit 130 carries out
        n_g = r_f + poly_pkg::ACC_W'(3'd5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) r_f <= n_f;
        if (r_v1)    r_sel <= n_g[130] ? n_g[poly_pkg::TAG_W-1:0] : r_f[poly_pkg::TAG_W-1:0];
        if (r_v2)    r_tag <= r_sel + i_s;
    end

    assign o_done = r_v3;
    assign o_tag  = r_tag;

`ifndef SYNTH
    a_fin_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> $past(i_start, 3))
        else $error("finisher result without a start three cycles back");
`endif

endmodule

### design/poly1305_mac.sv
// Top level of the Poly1305 one-time authenticator: control, padding and output register.
//
// Usage:
//   Load the 32-byte one-time key through the write port (index 0/1 = r low/high,
//   2/3 = s low/high) while the block is idle; r is clamped internally.
//   Input channel (i_in_valid / o_in_stall) moves one word per message block:
//   16 little-endian bytes, a byte count and a last flag. A count of 16 (or more)
//   is a full block; 1..15 a short block padded with 0x01; 0 absorbs nothing.
//   Output channel (o_out_valid / i_out_stall) moves one tag word per message.
// Sequence:
//   A block with data keeps the input stalled from acceptance until its product is
//   written back, so no new block is taken meanwhile: the add state forms h + m,
//   the bit-serial multiplier then takes one bit of clamped r per cycle, and the
//   product is written back to h.
//   A last block then passes the three finisher stages and the output load before
//   the tag shows; a count of zero with last set goes straight to the finisher.
//   The tag waits in the output register; the next message may start meanwhile,
//   and its own tag is held back until the receiver takes the first one.
// Reset clears the accumulator, key registers and all handshake state.
module poly1305_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [poly_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [poly_pkg::HALF_W-1:0]   i_cfg_data,
    // input blocks
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [poly_pkg::HALF_W-1:0]   i_block_low,
    input  logic [poly_pkg::HALF_W-1:0]   i_block_high,
    input  logic [4:0]                    i_byte_count,
    input  logic                          i_last_block,
    // tag output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [poly_pkg::HALF_W-1:0]   o_tag_low,
    output logic [poly_pkg::HALF_W-1:0]   o_tag_high
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_FIN,
        ST_FOUT
    } t_state;

    t_state                         r_state, n_state;
    logic [poly_pkg::ACC_W-1:0]     r_h, n_h;
    logic [poly_pkg::MSG_W-1:0]     r_m, n_m;
    logic                           r_last, n_last;
    logic                           r_out_valid, n_out_valid;
    logic [poly_pkg::TAG_W-1:0]     r_tag, n_tag;

    logic [poly_pkg::HALF_W-1:0]    r_cfg_r_low, r_cfg_r_high;
    logic [poly_pkg::HALF_W-1:0]    r_cfg_s_low, r_cfg_s_high;

    logic                           in_acc;
    logic                           out_free;
    logic [4:0]                     cnt;
    logic                           full;
    logic [poly_pkg::TAG_W-1:0]     blk;
    logic [poly_pkg::MSG_W-1:0]     pad_m;
    logic [poly_pkg::TAG_W-1:0]     r_key;

    logic                           mul_start, mul_done;
    logic [poly_pkg::SUM_W-1:0]     mul_a;
    logic [poly_pkg::ACC_W-1:0]     mul_prod;
    logic                           fin_start, fin_done;
    logic [poly_pkg::ACC_W-1:0]     fin_h;
    logic [poly_pkg::TAG_W-1:0]     fin_tag;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign r_key    = {r_cfg_r_high, r_cfg_r_low} & poly_pkg::R_CLAMP;
    assign blk      = {i_block_high, i_block_low};
    // counts above 16 saturate to a full block
    assign full     = i_byte_count[4];
    assign cnt      = i_byte_count;

    // message padding: keep bytes below the count, 0x01 at the count, bit 128 if full
    always_comb begin
        pad_m = '0;
        for (int k = 0; k < 16; k++) begin
            if (full || (5'(k) < cnt)) begin
                pad_m[8*k +: 8] = blk[8*k +: 8];
            end else if (5'(k) == cnt) begin
                pad_m[8*k +: 8] = 8'h01;
            end
        end
        pad_m[poly_pkg::MSG_W-1] = full;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_r_low  <= '0;
            r_cfg_r_high <= '0;
            r_cfg_s_low  <= '0;
            r_cfg_s_high <= '0;
        end else if (i_cfg_we) begin
            unique case (poly_pkg::t_cfg_reg'(i_cfg_addr))
                poly_pkg::CFG_R_LOW:  r_cfg_r_low  <= i_cfg_data;
                poly_pkg::CFG_R_HIGH: r_cfg_r_high <= i_cfg_data;
                poly_pkg::CFG_S_LOW:  r_cfg_s_low  <= i_cfg_data;
                poly_pkg::CFG_S_HIGH: r_cfg_s_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_m         = r_m;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_tag       = r_tag;
        mul_start   = 1'b0;
        mul_a       = {1'b0, r_h} + {3'b000, r_m};
        fin_start   = 1'b0;
        fin_h       = r_h;

        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_m    = pad_m;
                    n_last = i_last_block;
                    if (cnt != 5'd0) begin
                        n_state = ST_ADD;
                    end else if (i_last_block) begin
                        // empty absorb: finish from the current accumulator
                        fin_start = 1'b1;
                        n_state   = ST_FIN;
                    end
                end
            end
            ST_ADD: begin
                mul_start = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_h = mul_prod;
                    if (r_last) begin
                        fin_start = 1'b1;
                        fin_h     = mul_prod;
                        n_state   = ST_FIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (fin_done) n_state = ST_FOUT;
            end
            ST_FOUT: begin
                // tag held in the finisher until the output register frees up
                if (out_free) begin
                    n_tag       = fin_tag;
                    n_out_valid = 1'b1;
                    n_h         = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_h         <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h         <= n_h;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_m   <= n_m;
        r_tag <= n_tag;
    end

    poly_mmul u_mmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_r     (r_key[poly_pkg::R_BITS-1:0]),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    poly_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fin_start),
        .i_h     (fin_h),
        .i_s     ({r_cfg_s_high, r_cfg_s_low}),
        .o_done  (fin_done),
        .o_tag   (fin_tag)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_tag_low   = r_tag[poly_pkg::HALF_W-1:0];
    assign o_tag_high  = r_tag[poly_pkg::TAG_W-1:poly_pkg::HALF_W];

`ifndef SYNTH
    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_MUL))
        else $error("multiplier finished outside the multiply state");
    a_fin_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_done |-> (r_state == ST_FIN))
        else $error("finisher finished outside the finish state");
    a_tag_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == ST_FOUT))
        else $error("tag word raised without a finished message");
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOUT && out_free) |=> (r_h == '0))
        else $error("accumulator not cleared after tag");
`endif

endmodule

### tb/poly_tb_pkg.sv
`timescale 1ns / 100ps
// Tag predictor for the Poly1305 MAC testbench: key copy, limb accumulator, tags due.
package poly_tb_pkg;

    localparam bit [31:0] LIMB_MASK  = 32'h3ffffff;
    localparam bit [31:0] CLAMP_1    = 32'h3ffff03;
    localparam bit [31:0] CLAMP_2    = 32'h3ffc0ff;
    localparam bit [31:0] CLAMP_3    = 32'h3f03fff;
    localparam bit [31:0] CLAMP_4    = 32'h00fffff;
    localparam bit [31:0] HIBIT_128  = 32'h1000000;  // bit 128 seen from limb 4
    localparam bit [31:0] LIMB_4_TOP = 32'h4000000;  // 2^130 seen from limb 4
    localparam bit [4:0]  FULL_COUNT = 5'd16;

    typedef bit [4:0][31:0] t_limbs;
    typedef struct packed {
        bit [63:0] lo;
        bit [63:0] hi;
    } t_tag;

    // 128 bits as five 26-bit limbs, top limb 24 bits wide
    function automatic t_limbs split26(bit [63:0] lo, bit [63:0] hi);
        t_limbs l;
        l[0] = 32'(lo[25:0]);
        l[1] = 32'(lo[51:26]);
        l[2] = 32'({hi[13:0], lo[63:52]});
        l[3] = 32'(hi[39:14]);
        l[4] = 32'(hi[63:40]);
        return l;
    endfunction

    class t_tag_predictor;
        bit [63:0] r_lo, r_hi, s_lo, s_hi;
        t_limbs    acc;
        t_tag      tags_due[$];
        int        errors, blocks_seen, tags_checked;

        function void set_key(poly_pkg::t_cfg_reg idx, bit [63:0] val);
            case (idx)
                poly_pkg::CFG_R_LOW:  r_lo = val;
                poly_pkg::CFG_R_HIGH: r_hi = val;
                poly_pkg::CFG_S_LOW:  s_lo = val;
                poly_pkg::CFG_S_HIGH: s_hi = val;
                default: ;
            endcase
        endfunction

        // acc = (acc + m) * r, loosely reduced mod 2^130-5
        function void absorb_block(bit [63:0] lo, bit [63:0] hi, bit [31:0] hibit);
            t_limbs    r, m;
            bit [31:0] r5 [5];
            bit [63:0] d [5];
            bit [31:0] c, rv;
            r = split26(r_lo, r_hi);
            r[1] &= CLAMP_1;
            r[2] &= CLAMP_2;
            r[3] &= CLAMP_3;
            r[4] &= CLAMP_4;
            r5[0] = '0;
            for (int i = 1; i < 5; i++) r5[i] = r[i] * 32'd5;
            m = split26(lo, hi);
            m[4] |= hibit;
            for (int i = 0; i < 5; i++) acc[i] += m[i];
            for (int i = 0; i < 5; i++) begin
                d[i] = '0;
                for (int j = 0; j < 5; j++) begin
                    rv = (j <= i) ? r[i - j] : r5[i - j + 5];
                    d[i] += 64'(acc[j]) * 64'(rv);
                end
            end
            c = '0;
            for (int i = 0; i < 5; i++) begin
                d[i] += 64'(c);
                c = 32'(d[i] >> 26);
                acc[i] = 32'(d[i]) & LIMB_MASK;
            end
            acc[0] += c * 32'd5;
            c = acc[0] >> 26;
            acc[0] &= LIMB_MASK;
            acc[1] += c;
        endfunction

        // full reduction, then + s mod 2^128
        function t_tag close_tag();
            t_limbs    h, g;
            bit [31:0] c, keep_g;
            bit [63:0] lo, hi, sum;
            t_tag      t;
            h = acc;
            c = '0;
            for (int i = 1; i < 5; i++) begin
                h[i] += c;
                c = h[i] >> 26;
                h[i] &= LIMB_MASK;
            end
            h[0] += c * 32'd5;
            c = h[0] >> 26;
            h[0] &= LIMB_MASK;
            h[1] += c;
            g[0] = h[0] + 32'd5;
            c = g[0] >> 26;
            g[0] &= LIMB_MASK;
            for (int i = 1; i < 4; i++) begin
                g[i] = h[i] + c;
                c = g[i] >> 26;
                g[i] &= LIMB_MASK;
            end
            g[4] = h[4] + c - LIMB_4_TOP;
            keep_g = (g[4] >> 31) - 32'd1;  // all ones when h >= p
            for (int i = 0; i < 5; i++) h[i] = (h[i] & ~keep_g) | (g[i] & keep_g);
            lo = 64'(h[0]) | (64'(h[1]) << 26) | (64'(h[2]) << 52);
            hi = (64'(h[2]) >> 12) | (64'(h[3]) << 14) | (64'(h[4]) << 40);
            sum  = lo + s_lo;
            t.hi = hi + s_hi + 64'(sum < lo);
            t.lo = sum;
            return t;
        endfunction

        function void note_block(bit [63:0] lo, bit [63:0] hi, bit [4:0] cnt, bit is_last);
            bit [4:0]  n;
            bit [63:0] plo, phi;
            n   = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
            plo = lo;
            phi = hi;
            blocks_seen++;
            if (n == FULL_COUNT) begin
                absorb_block(plo, phi, HIBIT_128);
            end else if (n != 0) begin
                // short block: drop unused bytes, 0x01 right above the data
                if (n < 8) begin
                    plo = (plo & ((64'd1 << (8 * n)) - 64'd1)) | (64'd1 << (8 * n));
                    phi = '0;
                end else begin
                    phi = (phi & ((64'd1 << (8 * (n - 8))) - 64'd1))
                        | (64'd1 << (8 * (n - 8)));
                end
                absorb_block(plo, phi, '0);
            end
            if (is_last) begin
                tags_due.push_back(close_tag());
                acc = '0;
            end
        endfunction

        function void check_tag(bit [63:0] lo, bit [63:0] hi);
            t_tag want;
            tags_checked++;
            if (tags_due.size() == 0) begin
                $error("tag %h_%h arrived with no message closed", hi, lo);
                errors++;
                return;
            end
            want = tags_due.pop_front();
            if (lo != want.lo) begin
                $error("tag_low: expected %h, got %h", want.lo, lo);
                errors++;
            end
            if (hi != want.hi) begin
                $error("tag_high: expected %h, got %h", want.hi, hi);
                errors++;
            end
        endfunction

        function int pending();
            return tags_due.size();
        endfunction
    endclass

endpackage

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the Poly1305 MAC testbench: key loads, message block traffic and tag checking.
module testbench;

    // Settle time covers a data block's busy time plus the finisher and output load, with margin.
    localparam int DRAIN_CYCLES = 160;
    // Watchdog limit, set well above the slowest legal run.
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int SEGMENTS     = 6;
    localparam int SEG_WORDS    = 210;
    localparam bit [63:0] ALL_ONES = '1;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_addr   = '0;
    logic [63:0] i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_block_low  = '0;
    logic [63:0] i_block_high = '0;
    logic [4:0]  i_byte_count = '0;
    logic        i_last_block = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [63:0] o_tag_low;
    logic [63:0] o_tag_high;

    poly_tb_pkg::t_tag_predictor tag_pred = new;

    int send_idle_pct = 0;   // chance per cycle that the sender holds off
    int recv_idle_pct = 0;   // chance per cycle that the tag receiver stalls
    int cycles        = 0;
    int key_loads     = 0;

    poly1305_mac DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .i_byte_count (i_byte_count),
        .i_last_block (i_last_block),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tag_low    (o_tag_low),
        .o_tag_high   (o_tag_high)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Tag monitor. Sampling at the edge sees pre-edge values since all
    // drivers use nonblocking updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tag_pred.check_tag(o_tag_low, o_tag_high);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("** poly1305_mac: FAILED **");
            $finish;
        end
    end

    function automatic bit [63:0] rand_word();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0) return '0;
        if (sel == 1) return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    // Key halves: mostly random, sometimes the extremes.
    function automatic bit [63:0] key_half();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return '0;
        if (sel == 1) return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    task automatic set_pacing(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Leaves i_cfg_we high; load_key lowers it once after the last register.
    task automatic cfg_write(input poly_pkg::t_cfg_reg idx, input bit [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        tag_pred.set_key(idx, val);
        @(posedge i_clk);
    endtask

    task automatic load_key(input bit [63:0] rl, input bit [63:0] rh,
                            input bit [63:0] sl, input bit [63:0] sh);
        cfg_write(poly_pkg::CFG_R_LOW,  rl);
        cfg_write(poly_pkg::CFG_R_HIGH, rh);
        cfg_write(poly_pkg::CFG_S_LOW,  sl);
        cfg_write(poly_pkg::CFG_S_HIGH, sh);
        i_cfg_we <= 1'b0;
        key_loads++;
    endtask

    // One word on the input channel. Valid stays high into the next call
    // unless that call starts with a gap, so it is never dropped and raised
    // in the same step.
    task automatic send_block(input bit [63:0] lo, input bit [63:0] hi,
                              input bit [4:0] cnt, input bit is_last);
        int gap;
        gap = 0;
        if (send_idle_pct != 0) begin
            // now and then a long gap so idle time lands anywhere in the
            // bit-serial multiply and in the finisher
            if ($urandom_range(99) < 3) gap = $urandom_range(140, 1);
            while ($urandom_range(99) < send_idle_pct) gap++;
        end
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_block_low  <= lo;
        i_block_high <= hi;
        i_byte_count <= cnt;
        i_last_block <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        tag_pred.note_block(lo, hi, cnt, is_last);
    endtask

    task automatic drain_tags();
        i_in_valid <= 1'b0;
        while (tag_pred.pending() != 0) @(posedge i_clk);
    endtask

    // Block fully idle: tags out, and any open multiply done.
    task automatic settle();
        drain_tags();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed messages: 0..4 full blocks and a closing block that
    // is full, short, oversized or empty. The rest is noise: any count, either
    // flag, so short blocks also turn up mid-message.
    task automatic random_traffic(input int target, input bit hold_once);
        int       done_words, nfull, pick;
        bit [4:0] cnt;
        bit       is_last, held;
        done_words = 0;
        held       = 1'b0;
        while (done_words < target) begin
            if (hold_once && !held && done_words >= target / 2) begin
                // sender waits until every tag owed so far is out
                drain_tags();
                held = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 85) begin
                nfull = $urandom_range(4);
                repeat (nfull) begin
                    if ($urandom_range(19) == 0) begin
                        // zero count, not last: ignored, not counted
                        send_block(rand_word(), rand_word(), 5'd0, 1'b0);
                    end
                    send_block(rand_word(), rand_word(), poly_tb_pkg::FULL_COUNT, 1'b0);
                    done_words++;
                end
                pick = $urandom_range(99);
                if (pick < 55)      cnt = poly_tb_pkg::FULL_COUNT;
                else if (pick < 90) cnt = 5'($urandom_range(15, 1));
                else if (pick < 95) cnt = 5'($urandom_range(31, 17));
                else                cnt = 5'd0;
                send_block(rand_word(), rand_word(), cnt, 1'b1);
                done_words++;
            end else begin
                cnt     = 5'($urandom_range(31));
                is_last = 1'($urandom_range(1));
                send_block(rand_word(), rand_word(), cnt, is_last);
                if (cnt != 0 || is_last) done_words++;
            end
        end
        // close whatever message noise left open
        send_block(rand_word(), rand_word(), 5'($urandom_range(16)), 1'b1);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pacing: sender light / receiver heavy first, then swapped, then none.
        set_pacing(36, 56);

        // Zero key: empty message and any data both give a zero tag.
        load_key('0, '0, '0, '0);
        send_block('0, '0, 5'd0, 1'b1);
        send_block(ALL_ONES, ALL_ONES, poly_tb_pkg::FULL_COUNT, 1'b1);
        settle();

        // All-ones key: widest clamped r; s makes the final add wrap.
        load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_block(ALL_ONES, ALL_ONES, poly_tb_pkg::FULL_COUNT, 1'b0);
        send_block('0, '0, poly_tb_pkg::FULL_COUNT, 1'b0);
        send_block(rand_word(), rand_word(), 5'd0, 1'b0);    // absorbs nothing
        send_block(ALL_ONES, ALL_ONES, 5'd1, 1'b0);          // short block, message goes on
        send_block(ALL_ONES, ALL_ONES, 5'd15, 1'b1);
        send_block(ALL_ONES, ALL_ONES, 5'd8, 1'b1);          // pad byte at the half boundary
        send_block(ALL_ONES, ALL_ONES, 5'd7, 1'b1);
        send_block(ALL_ONES, ALL_ONES, 5'd31, 1'b0);         // oversized count acts as full
        send_block(rand_word(), rand_word(), 5'd17, 1'b1);
        send_block(rand_word(), rand_word(), 5'd9, 1'b1);
        send_block('0, '0, 5'd0, 1'b1);                       // empty message: tag is s
        settle();

        // r = 1: h is a plain sum; two all-ones blocks land it above 2^130-5
        // so the final subtraction has to kick in.
        load_key(64'd1, '0, '0, '0);
        send_block(ALL_ONES, ALL_ONES, poly_tb_pkg::FULL_COUNT, 1'b0);
        send_block(ALL_ONES, ALL_ONES, poly_tb_pkg::FULL_COUNT, 1'b0);
        send_block('0, '0, 5'd0, 1'b1);
        send_block(ALL_ONES, ALL_ONES, poly_tb_pkg::FULL_COUNT, 1'b0);
        send_block(ALL_ONES, ALL_ONES, poly_tb_pkg::FULL_COUNT, 1'b1);

        // Random traffic, new key per segment.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            if (seg == 2)      set_pacing(56, 36);
            else if (seg == 4) set_pacing(0, 0);
            load_key(key_half(), key_half(), key_half(), key_half());
            random_traffic(SEG_WORDS, seg == 1);
        end
        settle();

        $display("Sent %0d message blocks under %0d keys; %0d tags checked.",
                 tag_pred.blocks_seen, key_loads, tag_pred.tags_checked);
        $display("Pacing ran sender-light, receiver-light and unthrottled phases.");
        if (tag_pred.errors == 0) begin
            $display("** poly1305_mac: PASSED **");
        end else begin
            $display("** poly1305_mac: FAILED **");
        end
        $finish;
    end

endmodule
